>>> hw/rtl/blir_pkg.sv
// Shared constants, types and sequencer states for the linear interpolation resampler.
package blir_pkg;

  // Default parameter values
  localparam int MAX_BLOCK_DEF   = 8192;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_PER_BLOCK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_PER_BLOCK = 2'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] IN_PER_BLOCK_RST  = 14'd2100;
  localparam logic [CFG_W-1:0] OUT_PER_BLOCK_RST = 14'd2048;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_W,
    ST_MUL0,
    ST_MUL1,
    ST_DIV_S,
    ST_DIV_W,
    ST_STEP,
    ST_STEP_W,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/blir_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit in QW bits.
module blir_div #(
  parameter int POS_W = 14,
  parameter int QW    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [QW+POS_W-1:0]   dividend,
  input  logic [POS_W-1:0]      divisor,
  output logic [QW-1:0]         quotient,
  output logic [POS_W-1:0]      remainder,
  output blir_pkg::div_stat_t   stat
);

  localparam int DW = QW + POS_W;
  localparam int CW = $clog2(QW + 1);

  logic [POS_W-1:0] rem;
  logic [QW-1:0]    quo;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [POS_W:0]   trial;
  logic [POS_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem, quo[QW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  // Step counter and status
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DW-1:QW];
      quo <= dividend[QW-1:0];
    end else if (busy) begin
      rem <= fits ? diff[POS_W-1:0] : trial[POS_W-1:0];
      quo <= {quo[QW-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> hw/rtl/block_linear_interp_resampler_top.sv
// Block linear interpolation resampler: sequencer, blend datapath, registers and output stage.
// An item that yields an output goes through the remainder fold (only when the stored
// remainder must be folded after a register change), the two multiplies and the blend
// division per channel, then the step division; an item with no output commits on transfer.
// One item at a time; the shared divider runs three times per output item, four with a fold.
// Reset: synchronous, clears positions, previous sample and registers to their reset values.
module block_linear_interp_resampler_top #(
  parameter int MAX_BLOCK   = blir_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = blir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    i_sample,
  input  logic signed [SAMPLE_BITS-1:0]    q_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [blir_pkg::OUT_W-1:0] i_out,
  output logic signed [blir_pkg::OUT_W-1:0] q_out,
  output logic                             block_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blir_pkg::CFG_W-1:0]       cfg_data
);

  localparam int OUT_W = blir_pkg::OUT_W;
  localparam int CFG_W = blir_pkg::CFG_W;
  localparam int POS_W = $clog2(MAX_BLOCK + 1);
  localparam int NB_W  = POS_W + 1;
  localparam int QW    = (OUT_W > POS_W + 1) ? OUT_W : POS_W + 1;
  localparam int DW    = QW + POS_W;
  localparam int AW    = SAMPLE_BITS + POS_W + 2;
  localparam int SHIFT = OUT_W - SAMPLE_BITS;
  localparam int XW    = (AW + SHIFT > DW) ? AW + SHIFT : DW;

  // Configuration registers
  logic [CFG_W-1:0] in_per_block;
  logic [CFG_W-1:0] out_per_block;

  // Model state
  logic signed [SAMPLE_BITS-1:0] prev_i;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic [POS_W-1:0]              sample_pos;
  logic [POS_W-1:0]              out_index;
  logic [NB_W-1:0]               next_base;
  logic [POS_W-1:0]              phase_rem;

  // Working registers
  logic signed [SAMPLE_BITS-1:0] cur_i;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic [POS_W-1:0]              r;
  logic signed [AW-1:0]          acc;
  logic                          neg;
  logic                          on_q;
  logic signed [OUT_W-1:0]       res_i;
  logic signed [OUT_W-1:0]       res_q;

  blir_pkg::state_t state;
  blir_pkg::state_t state_next;

  // Combinational signals
  logic [31:0]                   ipb_ext;
  logic [31:0]                   opb_ext;
  logic [31:0]                   ie_ext;
  logic [31:0]                   oe_ext;
  logic [POS_W-1:0]              ie_sat;
  logic [POS_W-1:0]              oe_sat;
  logic                          pend;
  logic                          rem_ok;
  logic                          pos_wrap;
  logic                          out_free;
  logic                          in_xfer;
  logic                          commit;
  logic signed [SAMPLE_BITS-1:0] new_i;
  logic signed [SAMPLE_BITS-1:0] new_q;
  logic signed [SAMPLE_BITS-1:0] mul_x;
  logic [POS_W-1:0]              mul_w;
  logic signed [AW-1:0]          prod;
  logic signed [XW-1:0]          sacc;
  logic [XW-1:0]                 half;
  logic [XW-1:0]                 blend_num;
  logic [POS_W:0]                step_t;
  logic [QW-1:0]                 q_signed;
  logic                          div_start;
  logic [DW-1:0]                 div_dividend;
  logic [QW-1:0]                 div_quo;
  logic [POS_W-1:0]              div_rem;
  blir_pkg::div_stat_t           div_stat;

  // Shared divider
  blir_div #(
    .POS_W (POS_W),
    .QW    (QW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (oe_sat),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // Clamp the block sizes into their legal ranges
  always_comb begin
    ipb_ext = 32'(in_per_block);
    opb_ext = 32'(out_per_block);
    if (ipb_ext < 32'd2) begin
      ie_ext = 32'd2;
    end else if (ipb_ext > 32'(MAX_BLOCK)) begin
      ie_ext = 32'(MAX_BLOCK);
    end else begin
      ie_ext = ipb_ext;
    end
    if (opb_ext == 32'd0) begin
      oe_ext = 32'd1;
    end else if (opb_ext > ie_ext) begin
      oe_ext = ie_ext;
    end else begin
      oe_ext = opb_ext;
    end
    ie_sat = POS_W'(ie_ext);
    oe_sat = POS_W'(oe_ext);
  end

  // Status terms
  assign pend     = (next_base < NB_W'(sample_pos));
  assign rem_ok   = (phase_rem < oe_sat);
  assign pos_wrap = (sample_pos >= ie_sat);
  assign out_free = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign commit   = (in_xfer && !pend) || (state == blir_pkg::ST_OUT && out_free);
  assign new_i    = (state == blir_pkg::ST_IDLE) ? i_sample : cur_i;
  assign new_q    = (state == blir_pkg::ST_IDLE) ? q_sample : cur_q;

  // Multiply and blend arithmetic
  assign prod      = AW'(mul_x) * AW'($signed({1'b0, mul_w}));
  assign sacc      = XW'(acc) <<< SHIFT;
  assign half      = XW'(oe_sat >> 1);
  assign blend_num = acc[AW-1] ? (half - XW'(sacc)) : (XW'(sacc) + half);
  assign step_t    = {1'b0, r} + {1'b0, ie_sat};
  assign q_signed  = neg ? (QW'(0) - div_quo) : div_quo;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      blir_pkg::ST_IDLE:   if (in_valid && pend) state_next = blir_pkg::ST_RED;
      blir_pkg::ST_RED:    state_next = rem_ok ? blir_pkg::ST_MUL0 : blir_pkg::ST_RED_W;
      blir_pkg::ST_RED_W:  if (div_stat.done) state_next = blir_pkg::ST_MUL0;
      blir_pkg::ST_MUL0:   state_next = blir_pkg::ST_MUL1;
      blir_pkg::ST_MUL1:   state_next = blir_pkg::ST_DIV_S;
      blir_pkg::ST_DIV_S:  state_next = blir_pkg::ST_DIV_W;
      blir_pkg::ST_DIV_W: begin
        if (div_stat.done) begin
          state_next = on_q ? blir_pkg::ST_STEP : blir_pkg::ST_MUL0;
        end
      end
      blir_pkg::ST_STEP:   state_next = blir_pkg::ST_STEP_W;
      blir_pkg::ST_STEP_W: if (div_stat.done) state_next = blir_pkg::ST_OUT;
      blir_pkg::ST_OUT:    if (out_free) state_next = blir_pkg::ST_IDLE;
      default:             state_next = blir_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DW'(phase_rem);
    mul_x        = on_q ? prev_q : prev_i;
    mul_w        = oe_sat - r;
    case (state)
      blir_pkg::ST_IDLE: in_ready = 1'b1;
      blir_pkg::ST_RED:  div_start = !rem_ok;
      blir_pkg::ST_MUL1: begin
        mul_x = on_q ? cur_q : cur_i;
        mul_w = r;
      end
      blir_pkg::ST_DIV_S: begin
        div_start    = 1'b1;
        div_dividend = blend_num[DW-1:0];
      end
      blir_pkg::ST_STEP: begin
        div_start    = 1'b1;
        div_dividend = DW'(step_t);
      end
      default: ;
    endcase
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blir_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_per_block  <= blir_pkg::IN_PER_BLOCK_RST;
      out_per_block <= blir_pkg::OUT_PER_BLOCK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        blir_pkg::REG_IN_PER_BLOCK:  in_per_block  <= cfg_data;
        blir_pkg::REG_OUT_PER_BLOCK: out_per_block <= cfg_data;
        default: ;
      endcase
    end
  end

  // Model state: advance phase after the step division, commit sample at item end
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_i     <= '0;
      prev_q     <= '0;
      sample_pos <= '0;
      out_index  <= '0;
      next_base  <= '0;
      phase_rem  <= '0;
    end else begin
      if (state == blir_pkg::ST_STEP_W && div_stat.done) begin
        next_base <= next_base + NB_W'(div_quo);
        phase_rem <= div_rem;
      end
      if (commit) begin
        prev_i <= new_i;
        prev_q <= new_q;
        if (pos_wrap) begin
          sample_pos <= POS_W'(1);
          out_index  <= '0;
          next_base  <= '0;
          phase_rem  <= '0;
        end else begin
          sample_pos <= sample_pos + POS_W'(1);
          if (state == blir_pkg::ST_OUT) begin
            out_index <= out_index + POS_W'(1);
          end
        end
      end
    end
  end

  // Working registers of the blend
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_i <= i_sample;
      cur_q <= q_sample;
    end
    case (state)
      blir_pkg::ST_RED: begin
        on_q <= 1'b0;
        if (rem_ok) r <= phase_rem;
      end
      blir_pkg::ST_RED_W: if (div_stat.done) r <= div_rem;
      blir_pkg::ST_MUL0:  acc <= prod;
      blir_pkg::ST_MUL1:  acc <= acc + prod;
      blir_pkg::ST_DIV_S: neg <= acc[AW-1];
      blir_pkg::ST_DIV_W: begin
        if (div_stat.done) begin
          if (on_q) begin
            res_q <= q_signed[OUT_W-1:0];
          end else begin
            res_i <= q_signed[OUT_W-1:0];
          end
          on_q <= !on_q;
        end
      end
      default: ;
    endcase
  end

  // Output register: load on item end, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == blir_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == blir_pkg::ST_OUT && out_free) begin
      i_out      <= res_i;
      q_out      <= res_q;
      block_last <= (out_index == oe_sat - POS_W'(1));
    end
  end

  // Divider is started only when free
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A divider result arrives only in a state that waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == blir_pkg::ST_RED_W || state == blir_pkg::ST_DIV_W ||
                       state == blir_pkg::ST_STEP_W))
    else $error("divider result with no consumer");

  // Output register fills only at item end
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == blir_pkg::ST_OUT)
    else $error("output loaded outside item end");

  // Stored remainder stays below the output count after a step
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == blir_pkg::ST_STEP_W && div_stat.done) |=> (phase_rem < oe_sat))
    else $error("phase remainder out of range");

endmodule
